@@ sv/box_vertex_transform_engine_assert.svh @@
// Assertion macros for the box vertex transform engine.
// Used by box_vertex_transform_engine.sv; expects clk and arst_n in scope.
`ifndef BOX_VERTEX_TRANSFORM_ENGINE_ASSERT_SVH
`define BOX_VERTEX_TRANSFORM_ENGINE_ASSERT_SVH

// same-cycle implication
`define BVTE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bvte: assertion failed");

// next-cycle implication
`define BVTE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bvte: assertion failed");

`endif

@@ sv/bvte_pkg.sv @@
// Package for the box vertex transform engine: sizes, codes, reset pattern,
// rounding and saturation helpers. No dependencies.
package bvte_pkg;

	localparam int NUM_VERTICES = 8;
	localparam int FRAC_BITS    = 16;
	localparam int IDX_W        = $clog2(NUM_VERTICES);
	localparam int SUM_W        = 32 + IDX_W;

	// shared multiplier operand and product widths
	localparam int OPA_W  = 34;
	localparam int OPB_W  = 20;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int WIDE_W = PROD_W + 2;

	// 1/sqrt(2) at FRAC_BITS precision, rounded
	localparam longint ISO_K30 = 64'd759250125;
	localparam longint ISO_K   = (ISO_K30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
	localparam logic signed [WIDE_W-1:0] ONE_HALF = WIDE_W'(1) << (FRAC_BITS - 1);

	// command codes
	localparam logic [2:0] CMD_MOVE_PLUS  = 3'd0;
	localparam logic [2:0] CMD_MOVE_MINUS = 3'd1;
	localparam logic [2:0] CMD_ROT_CW     = 3'd2;
	localparam logic [2:0] CMD_ROT_CCW    = 3'd3;
	localparam logic [2:0] CMD_SCALE_UP   = 3'd4;
	localparam logic [2:0] CMD_SCALE_DOWN = 3'd5;

	// axis codes
	localparam logic [1:0] AXIS_X   = 2'd0;
	localparam logic [1:0] AXIS_Y   = 2'd1;
	localparam logic [1:0] AXIS_Z   = 2'd2;
	localparam logic [1:0] AXIS_BAD = 2'd3;

	// register indexes
	localparam logic [2:0] REG_SHIFT_STEP = 3'd0;
	localparam logic [2:0] REG_ROT_COS    = 3'd1;
	localparam logic [2:0] REG_ROT_SIN    = 3'd2;
	localparam logic [2:0] REG_SCALE_UP   = 3'd3;
	localparam logic [2:0] REG_SCALE_DOWN = 3'd4;

	// corner pattern, whole units
	function automatic logic [8:0] base_x(input logic [2:0] i);
		case (i)
			3'd1, 3'd2, 3'd5, 3'd6: return 9'd250;
			default:                return 9'd50;
		endcase
	endfunction

	function automatic logic [8:0] base_y(input logic [2:0] i);
		case (i)
			3'd0, 3'd1, 3'd4, 3'd5: return 9'd250;
			default:                return 9'd0;
		endcase
	endfunction

	function automatic logic [8:0] base_z(input logic [2:0] i);
		return i[2] ? 9'd50 : 9'd250;
	endfunction

	// mean of the reset corners, elaboration only
	function automatic longint cen_reset(input int ax);
		longint s;
		s = 0;
		for (int i = 0; i < NUM_VERTICES; i++) begin
			case (ax)
				0:       s = s + longint'(base_x(3'(i)));
				1:       s = s + longint'(base_y(3'(i)));
				default: s = s + longint'(base_z(3'(i)));
			endcase
		end
		return (s << FRAC_BITS) / NUM_VERTICES;
	endfunction

	localparam logic [31:0] CEN_X_RST = 32'(cen_reset(0));
	localparam logic [31:0] CEN_Y_RST = 32'(cen_reset(1));
	localparam logic [31:0] CEN_Z_RST = 32'(cen_reset(2));

	// round half up and drop the fraction
	function automatic logic signed [WIDE_W-1:0] rnd(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] t;
		t = v + ONE_HALF;
		return t >>> FRAC_BITS;
	endfunction

	// clamp to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		if (v > $signed({{(WIDE_W-32){1'b0}}, 32'h7FFF_FFFF}))
			return 32'sh7FFF_FFFF;
		else if (v < $signed({{(WIDE_W-32){1'b1}}, 32'h8000_0000}))
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

@@ sv/bvte_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on bvte_pkg for operand widths.
module bvte_mul import bvte_pkg::*; (
	input  logic                     clk,
	input  logic signed [OPA_W-1:0]  a,
	input  logic signed [OPB_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod_q
);

	// one product per cycle
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

@@ sv/box_vertex_transform_engine.sv @@
// Top level of the box vertex transform engine: sequencer, vertex store,
// output register. Depends on bvte_pkg, bvte_mul and the assertion header.
//
// Holds the box corners and their centroid; each command transfer moves,
// rotates or scales every corner (or nothing) and then streams one projected
// result per corner, the last with tlast. One shared multiplier does all the
// products under a step sequencer: a move updates each corner directly, a
// rotate or scale steps through its products per corner, the centroid is then
// summed corner by corner and divided, and each corner is projected in turn,
// waiting while the result stream is stalled. s_axis_tready is high only
// between commands. The user must write registers with cfg_we only while the
// block is idle; the block itself does not enforce this.
`include "box_vertex_transform_engine_assert.svh"

module box_vertex_transform_engine import bvte_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write port
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [30:0]  cfg_data,
	// command stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [2:0] command, [4:3] axis, rest zero
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,   // [2:0] vertex_index, [34:3] screen_x,
	                                     // [66:35] screen_y, [98:67] centroid_z
	output logic         m_axis_tuser,   // bad_axis
	output logic         m_axis_tlast    // last
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_CSUM,
		ST_CDIV,
		ST_PROJ
	} state_t;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_VERTICES - 1);

	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [2:0]         step_q;
	logic [2:0]         cmd_q;
	logic [1:0]         axis_q;
	logic               bad_q;

	logic [30:0]        shift_step_q;
	logic signed [17:0] rot_cos_q;
	logic signed [17:0] rot_sin_q;
	logic [18:0]        scale_up_q;
	logic [18:0]        scale_down_q;

	logic signed [31:0] vx_q [NUM_VERTICES];
	logic signed [31:0] vy_q [NUM_VERTICES];
	logic signed [31:0] vz_q [NUM_VERTICES];
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic signed [SUM_W-1:0] sx_q, sy_q, sz_q;

	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] prod;
	logic signed [31:0]       na_q;

	logic               out_valid_q;
	logic [2:0]         out_idx_q;
	logic signed [31:0] out_sx_q, out_sy_q, out_cz_q;
	logic               out_bad_q, out_last_q;

	// current corner and its offsets from the centroid
	logic signed [31:0] vx, vy, vz;
	logic signed [32:0] dx, dy, dz;
	logic signed [32:0] da, db;
	logic signed [31:0] ca, cb;
	logic signed [OPA_W-1:0] opa;
	logic signed [OPB_W-1:0] opb;
	logic signed [OPB_W-1:0] cos_b, sin_b, fac_b;

	assign vx = vx_q[idx_q];
	assign vy = vy_q[idx_q];
	assign vz = vz_q[idx_q];
	assign dx = {vx[31], vx} - {cx_q[31], cx_q};
	assign dy = {vy[31], vy} - {cy_q[31], cy_q};
	assign dz = {vz[31], vz} - {cz_q[31], cz_q};

	assign cos_b = OPB_W'(rot_cos_q);
	assign sin_b = (cmd_q == CMD_ROT_CCW) ? -OPB_W'(rot_sin_q) : OPB_W'(rot_sin_q);
	assign fac_b = (cmd_q == CMD_SCALE_UP) ? $signed({1'b0, scale_up_q})
	                                       : $signed({1'b0, scale_down_q});

	// rotation plane: (y,z) about x, (x,z) about y, (x,y) about z
	always_comb begin
		case (axis_q)
			AXIS_X:  begin da = dy; db = dz; ca = cy_q; cb = cz_q; end
			AXIS_Y:  begin da = dx; db = dz; ca = cx_q; cb = cz_q; end
			default: begin da = dx; db = dy; ca = cx_q; cb = cy_q; end
		endcase
	end

	// operand selection for the shared multiplier
	always_comb begin
		opa = '0;
		opb = '0;
		case (state_q)
			ST_UPD: begin
				if (cmd_q == CMD_ROT_CW || cmd_q == CMD_ROT_CCW) begin
					case (step_q)
						3'd0:    begin opa = OPA_W'(da); opb = cos_b; end
						3'd1:    begin opa = OPA_W'(db); opb = sin_b; end
						3'd2:    begin opa = OPA_W'(da); opb = sin_b; end
						3'd3:    begin opa = OPA_W'(db); opb = cos_b; end
						default: begin opa = '0; opb = '0; end
					endcase
				end else begin
					case (step_q)
						3'd0:    begin opa = OPA_W'(dx); opb = fac_b; end
						3'd1:    begin opa = OPA_W'(dy); opb = fac_b; end
						3'd2:    begin opa = OPA_W'(dz); opb = fac_b; end
						default: begin opa = '0; opb = '0; end
					endcase
				end
			end
			ST_PROJ: begin
				// dy*K is held while the result waits
				if (step_q == 3'd0) opa = OPA_W'(dx) + OPA_W'(dz);
				else                opa = OPA_W'(dy);
				opb = OPB_W'(ISO_K);
			end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	bvte_mul u_mul (
		.clk    (clk),
		.a      (opa),
		.b      (opb),
		.prod_q (prod)
	);

	// write-back values
	logic signed [31:0] mv_val, sc_val, nb_val, px_val, py_val;
	logic signed [31:0] mv_src, sc_ctr, na_val;
	logic signed [32:0] step_s;
	logic signed [OPA_W-1:0] dxz;

	always_comb begin
		case (axis_q)
			AXIS_X:  mv_src = vx;
			AXIS_Y:  mv_src = vy;
			default: mv_src = vz;
		endcase
		case (step_q)
			3'd1:    sc_ctr = cx_q;
			3'd2:    sc_ctr = cy_q;
			default: sc_ctr = cz_q;
		endcase
		step_s = $signed({2'b00, shift_step_q});
		if (cmd_q == CMD_MOVE_MINUS)
			mv_val = sat32(WIDE_W'(mv_src) - WIDE_W'(step_s));
		else
			mv_val = sat32(WIDE_W'(mv_src) + WIDE_W'(step_s));
		sc_val = sat32(rnd(WIDE_W'(prod)) + WIDE_W'(sc_ctr));
		na_val = sat32(rnd(WIDE_W'(acc_q) - WIDE_W'(prod)) + WIDE_W'(ca));
		nb_val = sat32(rnd(WIDE_W'(acc_q) + WIDE_W'(prod)) + WIDE_W'(cb));
		dxz    = OPA_W'(dx) - OPA_W'(dz);
		px_val = sat32(rnd(WIDE_W'(acc_q)) + WIDE_W'(cx_q));
		py_val = sat32(rnd((WIDE_W'(dxz) <<< (FRAC_BITS - 1)) + WIDE_W'(prod))
		               + WIDE_W'(cy_q));
	end

	// centroid: truncate toward zero
	function automatic logic signed [31:0] cdiv(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] t;
		t = s + (s[SUM_W-1] ? SUM_W'(NUM_VERTICES - 1) : SUM_W'(0));
		return 32'(t >>> IDX_W);
	endfunction

	logic is_rot, is_move, upd_last_step, out_free, out_load;
	assign is_rot  = (cmd_q == CMD_ROT_CW) || (cmd_q == CMD_ROT_CCW);
	assign is_move = (cmd_q == CMD_MOVE_PLUS) || (cmd_q == CMD_MOVE_MINUS);
	assign upd_last_step = is_move ? 1'b1 : (is_rot ? (step_q == 3'd4) : (step_q == 3'd3));
	assign out_free = !out_valid_q || m_axis_tready;
	// a projected corner enters the output register this cycle
	assign out_load = (state_q == ST_PROJ) && (step_q >= 3'd2) && out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_step_q <= 31'd655360;
			rot_cos_q    <= 18'sd65446;
			rot_sin_q    <= 18'sd3430;
			scale_up_q   <= 19'd78643;
			scale_down_q <= 19'd52429;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHIFT_STEP: shift_step_q <= cfg_data;
				REG_ROT_COS:    rot_cos_q    <= cfg_data[17:0];
				REG_ROT_SIN:    rot_sin_q    <= cfg_data[17:0];
				REG_SCALE_UP:   scale_up_q   <= cfg_data[18:0];
				REG_SCALE_DOWN: scale_down_q <= cfg_data[18:0];
				default: ;
			endcase
		end
	end

	// sequencer, vertex store and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			step_q      <= '0;
			cmd_q       <= '0;
			axis_q      <= '0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
			cx_q        <= CEN_X_RST;
			cy_q        <= CEN_Y_RST;
			cz_q        <= CEN_Z_RST;
			for (int i = 0; i < NUM_VERTICES; i++) begin
				vx_q[i] <= {7'd0, base_x(3'(i)), 16'd0} >>> (16 - FRAC_BITS);
				vy_q[i] <= {7'd0, base_y(3'(i)), 16'd0} >>> (16 - FRAC_BITS);
				vz_q[i] <= {7'd0, base_z(3'(i)), 16'd0} >>> (16 - FRAC_BITS);
			end
		end else begin
			if (m_axis_tready && !out_load) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q  <= '0;
					step_q <= '0;
					if (s_axis_tvalid) begin
						cmd_q  <= s_axis_tdata[2:0];
						axis_q <= s_axis_tdata[4:3];
						bad_q  <= (s_axis_tdata[2:0] <= CMD_ROT_CCW) &&
						          (s_axis_tdata[4:3] == AXIS_BAD);
						if ((s_axis_tdata[2:0] <= CMD_ROT_CCW) &&
						    (s_axis_tdata[4:3] == AXIS_BAD))
							state_q <= ST_PROJ;
						else if (s_axis_tdata[2:0] <= CMD_SCALE_DOWN)
							state_q <= ST_UPD;
						else
							state_q <= ST_PROJ;
					end
				end
				ST_UPD: begin
					if (is_move) begin
						case (axis_q)
							AXIS_X:  vx_q[idx_q] <= mv_val;
							AXIS_Y:  vy_q[idx_q] <= mv_val;
							default: vz_q[idx_q] <= mv_val;
						endcase
					end else if (is_rot) begin
						case (step_q)
							3'd1: acc_q <= prod;
							3'd2: na_q  <= na_val;
							3'd3: acc_q <= prod;
							3'd4: begin
								case (axis_q)
									AXIS_X:  begin vy_q[idx_q] <= na_q; vz_q[idx_q] <= nb_val; end
									AXIS_Y:  begin vx_q[idx_q] <= na_q; vz_q[idx_q] <= nb_val; end
									default: begin vx_q[idx_q] <= na_q; vy_q[idx_q] <= nb_val; end
								endcase
							end
							default: ;
						endcase
					end else begin
						case (step_q)
							3'd1: vx_q[idx_q] <= sc_val;
							3'd2: vy_q[idx_q] <= sc_val;
							3'd3: vz_q[idx_q] <= sc_val;
							default: ;
						endcase
					end
					if (upd_last_step) begin
						step_q <= '0;
						idx_q  <= idx_q + 1'b1;
						if (idx_q == IDX_LAST) begin
							state_q <= ST_CSUM;
							sx_q    <= '0;
							sy_q    <= '0;
							sz_q    <= '0;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_CSUM: begin
					sx_q  <= sx_q + SUM_W'(vx);
					sy_q  <= sy_q + SUM_W'(vy);
					sz_q  <= sz_q + SUM_W'(vz);
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_LAST) state_q <= ST_CDIV;
				end
				ST_CDIV: begin
					cx_q    <= cdiv(sx_q);
					cy_q    <= cdiv(sy_q);
					cz_q    <= cdiv(sz_q);
					idx_q   <= '0;
					step_q  <= '0;
					state_q <= ST_PROJ;
				end
				ST_PROJ: begin
					case (step_q)
						3'd0: step_q <= 3'd1;
						3'd1: begin
							acc_q  <= prod;
							step_q <= 3'd2;
						end
						default: begin
							if (out_free) begin
								out_valid_q <= 1'b1;
								out_idx_q   <= 3'(idx_q);
								out_sx_q    <= px_val;
								out_sy_q    <= py_val;
								out_cz_q    <= cz_q;
								out_bad_q   <= bad_q;
								out_last_q  <= (idx_q == IDX_LAST);
								step_q      <= '0;
								idx_q       <= idx_q + 1'b1;
								if (idx_q == IDX_LAST) state_q <= ST_IDLE;
							end
						end
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_cz_q, out_sy_q, out_sx_q, out_idx_q};
	assign m_axis_tuser  = out_bad_q;
	assign m_axis_tlast  = out_last_q;

	`BVTE_ASSERT_NEXT(a_busy_after_cmd, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`BVTE_ASSERT_NOW(a_last_is_final, m_axis_tvalid && m_axis_tlast, out_idx_q == 3'(IDX_LAST))
	`BVTE_ASSERT_NEXT(a_hold_while_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}))

endmodule
